### hw/rtl/scst_pkg.sv
// scst_pkg: shared types and constants of the serial-set countdown timer
// no dependencies; imported by every module of the block
package scst_pkg;

  // line buffer limit; a line ends once LINE_LIMIT-1 bytes are held
  localparam int unsigned LINE_LIMIT = 20;
  localparam int unsigned LCNT_W     = 5;

  // field widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned DISP_W    = 17;
  localparam int unsigned SERVO_W   = 2;
  localparam int unsigned TDIV_W    = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned OUT_BITS  = SERVO_W + DISP_W + CNT_W + 2;
  localparam int unsigned OUT_TD_W  = ((OUT_BITS + 7) / 8) * 8;

  // reset values
  localparam logic [TDIV_W-1:0] TICK_DIVIDE_RST  = 8'd4;
  localparam logic [CNT_W-1:0]  WARN_SECONDS_RST = 16'd300;
  localparam logic [CNT_W-1:0]  COUNTDOWN_RST    = 16'd350;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_DIVIDE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WARN_SECONDS = 1'd1;

  // special characters
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'd0;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'd43;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'd45;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'd57;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
  localparam logic [BYTE_W-1:0] CH_B     = 8'd98;
  localparam logic [BYTE_W-1:0] CH_L     = 8'd108;
  localparam logic [BYTE_W-1:0] CH_S     = 8'd115;

  // reciprocal of 60 scaled by 2^21, exact for every 16-bit value
  localparam logic [CNT_W-1:0] RECIP60 = 16'd34953;
  localparam int unsigned RECIP_SH = 21;
  localparam int unsigned MIN_W    = 11;

  typedef enum logic [SERVO_W-1:0] {
    SERVO_DOWN = 2'd0,
    SERVO_MID  = 2'd1,
    SERVO_UP   = 2'd2
  } servo_t;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } parse_phase_t;

  typedef enum logic [1:0] {
    CMD_BRAKE   = 2'd0,
    CMD_LECTURE = 2'd1,
    CMD_STOP    = 2'd2,
    CMD_OTHER   = 2'd3
  } cmd_t;

  // end-of-line event from the parser to the timer
  typedef struct packed {
    logic             done;
    logic             empty;
    cmd_t             cmd;
    logic [CNT_W-1:0] secs;
  } line_evt_t;

  // visible timer state
  typedef struct packed {
    logic              day_finished;
    logic              brake_active;
    logic [CNT_W-1:0]  seconds_remaining;
    logic [DISP_W-1:0] display_value;
    servo_t            servo_position;
  } timer_state_t;

endpackage

### hw/rtl/serial_set_countdown_timer.sv
// serial_set_countdown_timer: top level with input and result registers
// depends on scst_pkg, scst_line_parser, scst_timer
//
// channel | direction | contents
// in_     | input     | tdata: rx_byte[7:0]; tuser: mode (0 byte, 1 tick)
// out_    | output    | tdata: servo_position, display_value, seconds_remaining,
//         |           |        brake_active, day_finished (from bit 0 up)
// cfg_    | input     | write enable, register index, write data
//
// one word per cycle while out_ does not stall; a word taken passes the input register,
// then the timer update writes its result into the result register
// reset is synchronous; valid flags, configuration, parser and timer state return to reset values
// a stalled result holds in the result register while the input register
// still drains into it as soon as out_tready takes the held word
module serial_set_countdown_timer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [scst_pkg::BYTE_W-1:0]      in_tdata,   // rx_byte[7:0]
  input  logic                             in_tuser,   // mode
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // servo_position[1:0], display_value[18:2], seconds_remaining[34:19],
  // brake_active[35], day_finished[36], zero fill[39:37]
  output logic [scst_pkg::OUT_TD_W-1:0]    out_tdata,
  input  logic                             cfg_we,
  input  logic [scst_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scst_pkg::CFG_W-1:0]       cfg_wdata
);
  import scst_pkg::*;

  logic              s1_valid_r;
  logic              s1_mode_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              out_valid_r;
  logic [OUT_TD_W-1:0] out_data_r;
  logic [TDIV_W-1:0] tick_divide_r;
  logic [CNT_W-1:0]  warn_seconds_r;
  logic              s1_go;
  line_evt_t         evt;
  timer_state_t      tstate;

  // handshake
  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_divide_r  <= TICK_DIVIDE_RST;
      warn_seconds_r <= WARN_SECONDS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TICK_DIVIDE:  tick_divide_r  <= cfg_wdata[TDIV_W-1:0];
        CFG_WARN_SECONDS: warn_seconds_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_mode_r <= in_tuser;
      s1_byte_r <= in_tdata;
    end
  end

  // line parsing and timer state
  scst_line_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_step (s1_go && !s1_mode_r),
    .rx_byte   (s1_byte_r),
    .evt       (evt)
  );

  scst_timer u_timer (
    .clk          (clk),
    .rst_n        (rst_n),
    .tick_step    (s1_go && s1_mode_r),
    .evt          (evt),
    .tick_divide  (tick_divide_r),
    .warn_seconds (warn_seconds_r),
    .state        (tstate)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) out_data_r <= OUT_TD_W'(tstate);
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### hw/rtl/scst_line_parser.sv
// scst_line_parser: gathers serial bytes into a line and parses minutes
// depends on scst_pkg
module scst_line_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          byte_step,
  input  logic [scst_pkg::BYTE_W-1:0]   rx_byte,
  output scst_pkg::line_evt_t           evt
);
  import scst_pkg::*;

  logic [LCNT_W-1:0] line_count_r, line_count_nxt;
  logic [BYTE_W-1:0] cmd_char_r, cmd_char_nxt;
  parse_phase_t      phase_r, phase_nxt;
  logic              neg_r, neg_nxt;
  logic [CNT_W-1:0]  acc_r, acc_nxt;

  logic              line_end;
  logic              is_digit;
  logic              is_blank;
  logic [CNT_W-1:0]  acc_digit;
  logic [CNT_W-1:0]  minutes;

  // character classes
  assign line_end = (rx_byte == CH_LF) || (line_count_r >= LCNT_W'(LINE_LIMIT - 1));
  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign is_blank = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));
  assign acc_digit = (acc_r << 3) + (acc_r << 1) + CNT_W'(rx_byte - CH_ZERO);

  // next line state
  always_comb begin
    line_count_nxt = line_count_r;
    cmd_char_nxt   = cmd_char_r;
    phase_nxt      = phase_r;
    neg_nxt        = neg_r;
    acc_nxt        = acc_r;
    if (byte_step) begin
      if (line_end) begin
        line_count_nxt = '0;
        cmd_char_nxt   = CH_NUL;
        phase_nxt      = PH_SKIP;
        neg_nxt        = 1'b0;
        acc_nxt        = '0;
      end else if (rx_byte != CH_CR) begin
        line_count_nxt = line_count_r + LCNT_W'(1);
        if (line_count_r == '0) begin
          cmd_char_nxt = rx_byte;
          if (rx_byte == CH_NUL) phase_nxt = PH_DONE;
        end else if (rx_byte == CH_NUL) begin
          phase_nxt = PH_DONE;
        end else begin
          case (phase_r)
            PH_SKIP: begin
              if (!is_blank) begin
                if (rx_byte == CH_PLUS) begin
                  phase_nxt = PH_DIGITS;
                end else if (rx_byte == CH_MINUS) begin
                  neg_nxt   = 1'b1;
                  phase_nxt = PH_DIGITS;
                end else if (is_digit) begin
                  acc_nxt   = acc_digit;
                  phase_nxt = PH_DIGITS;
                end else begin
                  phase_nxt = PH_DONE;
                end
              end
            end
            PH_DIGITS: begin
              if (is_digit) acc_nxt = acc_digit;
              else          phase_nxt = PH_DONE;
            end
            default: phase_nxt = phase_r;
          endcase
        end
      end
    end
  end

  // end-of-line event: command kind and minutes*60
  assign minutes = neg_r ? (CNT_W'(0) - acc_r) : acc_r;

  always_comb begin
    evt.done  = byte_step && line_end;
    evt.empty = (line_count_r == '0);
    evt.secs  = (minutes << 6) - (minutes << 2);
    case (cmd_char_r)
      CH_B:    evt.cmd = CMD_BRAKE;
      CH_L:    evt.cmd = CMD_LECTURE;
      CH_S:    evt.cmd = CMD_STOP;
      default: evt.cmd = CMD_OTHER;
    endcase
  end

  // line registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_count_r <= '0;
      cmd_char_r   <= CH_NUL;
      phase_r      <= PH_SKIP;
      neg_r        <= 1'b0;
      acc_r        <= '0;
    end else begin
      line_count_r <= line_count_nxt;
      cmd_char_r   <= cmd_char_nxt;
      phase_r      <= phase_nxt;
      neg_r        <= neg_nxt;
      acc_r        <= acc_nxt;
    end
  end

endmodule

### hw/rtl/scst_timer.sv
// scst_timer: countdown, tick divider, servo and display state
// depends on scst_pkg; takes line events from scst_line_parser
module scst_timer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          tick_step,
  input  scst_pkg::line_evt_t           evt,
  input  logic [scst_pkg::TDIV_W-1:0]   tick_divide,
  input  logic [scst_pkg::CNT_W-1:0]    warn_seconds,
  output scst_pkg::timer_state_t        state
);
  import scst_pkg::*;

  logic [CNT_W-1:0]  countdown_r, countdown_nxt;
  logic [TDIV_W-1:0] tick_count_r, tick_count_nxt;
  logic              brake_r, brake_nxt;
  logic              day_done_r, day_done_nxt;
  servo_t            servo_r, servo_nxt;
  logic [DISP_W-1:0] display_r, display_nxt;

  logic [TDIV_W-1:0]     tick_dec;
  logic [CNT_W-1:0]      cd_dec;
  logic [2*CNT_W-1:0]    recip_prod;
  logic [MIN_W-1:0]      disp_min;
  logic [CNT_W-1:0]      min_x60;
  logic [CNT_W-1:0]      disp_sec;
  logic [DISP_W-1:0]     disp_val;

  // one second step and its display value
  assign tick_dec   = tick_count_r - TDIV_W'(1);
  assign cd_dec     = countdown_r - CNT_W'(1);
  assign recip_prod = cd_dec * RECIP60;
  assign disp_min   = recip_prod[RECIP_SH +: MIN_W];
  assign min_x60    = (CNT_W'(disp_min) << 6) - (CNT_W'(disp_min) << 2);
  assign disp_sec   = cd_dec - min_x60;
  assign disp_val   = (DISP_W'(disp_min) << 6) + (DISP_W'(disp_min) << 5)
                    + (DISP_W'(disp_min) << 2) + DISP_W'(disp_sec);

  // next timer state
  always_comb begin
    countdown_nxt  = countdown_r;
    tick_count_nxt = tick_count_r;
    brake_nxt      = brake_r;
    day_done_nxt   = day_done_r;
    servo_nxt      = servo_r;
    display_nxt    = display_r;
    if (tick_step) begin
      tick_count_nxt = tick_dec;
      if (tick_dec == '0) begin
        countdown_nxt  = cd_dec;
        display_nxt    = disp_val;
        tick_count_nxt = tick_divide;
        if ((cd_dec == warn_seconds) && !brake_r) servo_nxt = SERVO_MID;
      end
    end else if (evt.done) begin
      if (evt.empty) begin
        countdown_nxt = '0;
      end else begin
        case (evt.cmd)
          CMD_BRAKE: begin
            brake_nxt     = 1'b1;
            servo_nxt     = SERVO_UP;
            countdown_nxt = evt.secs;
          end
          CMD_LECTURE: begin
            brake_nxt     = 1'b0;
            servo_nxt     = SERVO_DOWN;
            countdown_nxt = evt.secs;
          end
          CMD_STOP: begin
            brake_nxt    = 1'b0;
            day_done_nxt = 1'b1;
          end
          default: countdown_nxt = evt.secs;
        endcase
      end
    end
  end

  // timer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      countdown_r  <= COUNTDOWN_RST;
      tick_count_r <= TICK_DIVIDE_RST;
      brake_r      <= 1'b0;
      day_done_r   <= 1'b0;
      servo_r      <= SERVO_DOWN;
      display_r    <= '0;
    end else begin
      countdown_r  <= countdown_nxt;
      tick_count_r <= tick_count_nxt;
      brake_r      <= brake_nxt;
      day_done_r   <= day_done_nxt;
      servo_r      <= servo_nxt;
      display_r    <= display_nxt;
    end
  end

  // state after the current word
  assign state.day_finished      = day_done_nxt;
  assign state.brake_active      = brake_nxt;
  assign state.seconds_remaining = countdown_nxt;
  assign state.display_value     = display_nxt;
  assign state.servo_position    = servo_nxt;

endmodule

### hw/rtl/scst_checker.sv
// scst_checker: port-level checks of serial_set_countdown_timer
// depends on scst_pkg; bound to the top level at the end of this file
module scst_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [scst_pkg::OUT_TD_W-1:0] out_tdata
);
  import scst_pkg::*;

  // a held result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // servo code is always one of the three positions
  a_servo_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[SERVO_W-1:0] != 2'd3)
    else $error("servo position code out of range");

  // brake always comes with the servo up
  a_brake_up: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[SERVO_W+DISP_W+CNT_W]
      |-> out_tdata[SERVO_W-1:0] == SERVO_UP)
    else $error("brake active without servo up");

  // result word fill bits stay zero
  a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TD_W-1:OUT_BITS] == '0)
    else $error("fill bits of result word not zero");

endmodule

bind serial_set_countdown_timer scst_checker u_scst_checker (.*);

### tb/serial_set_countdown_timer_test.sv
// serial_set_countdown_timer_test: self-checking testbench of the countdown timer
// drives serial bytes and timer ticks, predicts every result word, and checks it
// depends on scst_pkg and serial_set_countdown_timer
`timescale 1ns / 1ps

module serial_set_countdown_timer_test;
  import scst_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 250;

  typedef struct packed {
    logic             tick;
    logic [BYTE_W-1:0] ch;
  } rx_word_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [BYTE_W-1:0]    in_tdata = '0;   // rx_byte[7:0]
  logic                 in_tuser = 1'b0; // mode
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  // servo_position[1:0], display_value[18:2], seconds_remaining[34:19],
  // brake_active[35], day_finished[36], zero fill[39:37]
  logic [OUT_TD_W-1:0]  out_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // words waiting to be sent and timer states waiting to come back
  rx_word_t     word_q[$];
  timer_state_t timer_state_q[$];
  int           queued_total = 0;
  int           error_count = 0;

  // predicted timer state
  logic [TDIV_W-1:0] tick_div = TICK_DIVIDE_RST;
  logic [CNT_W-1:0]  warn_secs = WARN_SECONDS_RST;
  logic [CNT_W-1:0]  cd = COUNTDOWN_RST;
  logic [TDIV_W-1:0] tick_cnt = TICK_DIVIDE_RST;
  logic              brake = 1'b0;
  logic              day_done = 1'b0;
  servo_t            servo = SERVO_DOWN;
  logic [DISP_W-1:0] disp = '0;
  logic [LCNT_W-1:0] line_len = '0;
  logic [BYTE_W-1:0] cmd_char = '0;
  parse_phase_t      phase = PH_SKIP;
  logic              neg = 1'b0;
  logic [CNT_W-1:0]  minutes_acc = '0;

  // handshake bookkeeping shared between the clock edges
  logic in_fire = 1'b0;
  int   quiet_cycles = 0;
  int   gap_left = 0;
  int   burst_left = 0;
  int   hold_asked = 0;
  int   hold_served = 0;
  int   hold_left = 0;
  int   stall_style = 0;
  int   style_left = 0;
  int   rx_cycle = 0;

  serial_set_countdown_timer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic logic is_blank(input logic [BYTE_W-1:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // apply one byte or tick to the predicted state and queue the visible state
  task automatic advance_timer(input logic tick, input logic [BYTE_W-1:0] c);
    logic [CNT_W-1:0] mins;
    logic [CNT_W-1:0] secs;
    timer_state_t     view;
    if (tick) begin
      tick_cnt = tick_cnt - 8'd1;
      if (tick_cnt == '0) begin
        cd = cd - 16'd1;
        disp = 17'(cd / 16'd60) * 17'd100 + 17'(cd % 16'd60);
        tick_cnt = tick_div;
        if (cd == warn_secs && !brake) servo = SERVO_MID;
      end
    end else if (c == CH_LF || line_len >= LCNT_W'(LINE_LIMIT - 1)) begin
      // end of line: run the command
      mins = neg ? 16'd0 - minutes_acc : minutes_acc;
      secs = mins * 16'd60;
      if (line_len == '0) begin
        cd = '0;
      end else if (cmd_char == CH_B) begin
        brake = 1'b1;
        servo = SERVO_UP;
        cd = secs;
      end else if (cmd_char == CH_L) begin
        brake = 1'b0;
        servo = SERVO_DOWN;
        cd = secs;
      end else if (cmd_char == CH_S) begin
        brake = 1'b0;
        day_done = 1'b1;
      end else begin
        cd = secs;
      end
      line_len = '0;
      cmd_char = '0;
      phase = PH_SKIP;
      neg = 1'b0;
      minutes_acc = '0;
    end else if (c != CH_CR) begin
      // store the byte: command char first, then the minutes number
      if (line_len == '0) begin
        cmd_char = c;
        if (c == CH_NUL) phase = PH_DONE;
      end else if (c == CH_NUL) begin
        phase = PH_DONE;
      end else if (phase == PH_SKIP) begin
        if (!is_blank(c)) begin
          if (c == CH_PLUS) begin
            phase = PH_DIGITS;
          end else if (c == CH_MINUS) begin
            neg = 1'b1;
            phase = PH_DIGITS;
          end else if (c >= CH_ZERO && c <= CH_NINE) begin
            minutes_acc = minutes_acc * 16'd10 + {8'd0, c - CH_ZERO};
            phase = PH_DIGITS;
          end else begin
            phase = PH_DONE;
          end
        end
      end else if (phase == PH_DIGITS) begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          minutes_acc = minutes_acc * 16'd10 + {8'd0, c - CH_ZERO};
        end else begin
          phase = PH_DONE;
        end
      end
      line_len = line_len + 5'd1;
    end
    view.day_finished = day_done;
    view.brake_active = brake;
    view.seconds_remaining = cd;
    view.display_value = disp;
    view.servo_position = servo;
    timer_state_q.push_back(view);
  endtask

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      error_count++;
    end
  endfunction

  // input side: predict each accepted word, and watch for a hang
  always @(posedge clk) begin
    in_fire = rst_n && in_tvalid && in_tready;
    if (in_fire) advance_timer(in_tuser, in_tdata);
    if (in_fire || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // result side: compare each word with the oldest predicted state
  always @(posedge clk) begin
    timer_state_t got;
    timer_state_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[OUT_BITS-1:0];
      if (timer_state_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got %h", $time, got);
        error_count++;
      end else begin
        want = timer_state_q.pop_front();
        check_field("servo_position", want.servo_position, got.servo_position);
        check_field("display_value", want.display_value, got.display_value);
        check_field("seconds_remaining", want.seconds_remaining, got.seconds_remaining);
        check_field("brake_active", want.brake_active, got.brake_active);
        check_field("day_finished", want.day_finished, got.day_finished);
      end
    end
  end

  // sender: bursts of words with random gaps
  always @(negedge clk) begin
    rx_word_t next;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (word_q.size() > 0) begin
        next = word_q.pop_front();
        in_tuser <= next.tick;
        in_tdata <= next.ch;
        in_tvalid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall styles that change now and then, plus long hold-offs on request
  always @(negedge clk) begin
    rx_cycle++;
    if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        stall_style = $urandom_range(0, 3);
        style_left = $urandom_range(20, 150);
      end
      style_left--;
      case (stall_style)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        2:       out_tready <= ($urandom_range(0, 9) != 0);
        default: out_tready <= ((rx_cycle % 7) < 4);
      endcase
    end
  end

  task automatic queue_word(input logic tick, input logic [BYTE_W-1:0] ch);
    rx_word_t w;
    w.tick = tick;
    w.ch = ch;
    word_q.push_back(w);
    queued_total++;
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_word(1'b0, s[i]);
  endtask

  // mostly well-formed command lines followed by ticks, plus noise and broken lines
  task automatic queue_random_words(input int n);
    int               stop_at;
    int               pick;
    int               count;
    int               ndig;
    logic [BYTE_W-1:0] ch;
    stop_at = queued_total + n;
    while (queued_total < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        case ($urandom_range(0, 9))
          0, 1, 2: ch = CH_B;
          3, 4, 5: ch = CH_L;
          6:       ch = CH_S;
          7:       ch = 8'($urandom_range(33, 126));
          8:       ch = CH_NUL;
          default: ch = 8'($urandom_range(0, 255));
        endcase
        queue_word(1'b0, ch);
        // leading white space, then an optional sign
        repeat ($urandom_range(0, 2)) begin
          case ($urandom_range(0, 2))
            0:       queue_word(1'b0, CH_SPACE);
            1:       queue_word(1'b0, CH_TAB);
            default: queue_word(1'b0, 8'($urandom_range(11, 12)));
          endcase
        end
        case ($urandom_range(0, 5))
          0:       queue_word(1'b0, CH_PLUS);
          1:       queue_word(1'b0, CH_MINUS);
          default: ;
        endcase
        // small minute counts mostly, so warnings and wraps are reached
        ndig = ($urandom_range(0, 15) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 2);
        repeat (ndig) queue_word(1'b0, CH_ZERO + 8'($urandom_range(0, (ndig == 1) ? 4 : 9)));
        if ($urandom_range(0, 3) == 0) queue_word(1'b0, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) == 0) queue_word(1'b0, CH_CR);
        queue_word(1'b0, CH_LF);
        repeat ($urandom_range(0, 15)) queue_word(1'b1, 8'($urandom_range(0, 255)));
      end else if (pick < 70) begin
        count = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
        repeat (count) queue_word(1'b1, 8'($urandom_range(0, 255)));
      end else if (pick < 82) begin
        repeat ($urandom_range(1, 6)) queue_word(1'($urandom_range(0, 1)),
                                                 8'($urandom_range(0, 255)));
      end else if (pick < 94) begin
        // line that fills up before any newline
        repeat ($urandom_range(19, 23)) begin
          do ch = 8'($urandom_range(0, 255)); while (ch == CH_LF);
          queue_word(1'b0, ch);
        end
        if ($urandom_range(0, 1) == 0) queue_word(1'b0, CH_LF);
      end else begin
        if ($urandom_range(0, 1) == 0) queue_word(1'b0, CH_CR);
        queue_word(1'b0, CH_LF);
      end
    end
  endtask

  task automatic wait_drained;
    while (word_q.size() != 0 || in_tvalid || timer_state_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TICK_DIVIDE) begin
      tick_div = TDIV_W'(value);
    end else begin
      warn_secs = CNT_W'(value);
    end
  endtask

  // new settings once the block is idle, then a random stretch of words
  task automatic run_phase(input int unsigned tdiv, input int unsigned warn, input int n,
                           input bit hold);
    wait_drained();
    write_reg(CFG_TICK_DIVIDE, tdiv);
    write_reg(CFG_WARN_SECONDS, warn);
    queue_random_words(n);
    if (hold) hold_asked++;
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed: brake with carriage return, negative lecture, empty line then
    // countdown wrap below zero, zero first byte, stop, wrapping minute count
    queue_text("b12");
    queue_word(1'b0, CH_CR);
    queue_word(1'b0, CH_LF);
    queue_text("l-1");
    queue_word(1'b0, CH_LF);
    queue_word(1'b0, CH_LF);
    queue_word(1'b1, 8'h00);
    queue_word(1'b1, 8'hff);
    queue_word(1'b1, 8'h00);
    queue_word(1'b1, 8'h00);
    queue_word(1'b0, CH_NUL);
    queue_word(1'b0, CH_LF);
    queue_text("s");
    queue_word(1'b0, CH_LF);
    queue_text("q70000");
    queue_word(1'b0, CH_LF);

    run_phase(1, 118, 450, 1'b1);
    run_phase(1, 65535, 250, 1'b0);
    run_phase(255, 0, 200, 1'b0);
    run_phase(0, 177, 400, 1'b0);
    run_phase(2, 60 * $urandom_range(1, 4) - $urandom_range(1, 12), 300, 1'b1);

    wait_drained();
    repeat (10) @(negedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
